// ===== hdl/ymr_pkg.sv =====
// ----------------------------------------------------------------------------
// ymr_pkg
// Types and constants shared by the YMODEM receiver.
// ----------------------------------------------------------------------------
package ymr_pkg;

  localparam int unsigned LongBlockDef  = 1024;
  localparam int unsigned ShortBlockDef = 128;
  localparam logic [31:0] TimeoutRst    = 32'd3000;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChC   = 8'h43;
  localparam logic [30:0] SizeMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    K_SEND    = 3'd0,
    K_NAME    = 3'd1,
    K_PAYLOAD = 3'd2,
    K_HDR_OK  = 3'd3,
    K_BLK_OK  = 3'd4,
    K_SUCCESS = 3'd5,
    K_ERROR   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_START    = 3'd1,
    E_TIMEOUT  = 3'd2,
    E_SEQ      = 3'd3,
    E_COMP     = 3'd4,
    E_CRC      = 3'd5,
    E_END      = 3'd6
  } cause_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WAIT_START = 4'd1,
    PH_HDR_PKT    = 4'd2,
    PH_DATA_WAIT  = 4'd3,
    PH_DATA_PKT   = 4'd4,
    PH_END_EOT    = 4'd5,
    PH_FINAL_WAIT = 4'd6,
    PH_FINAL_PKT  = 4'd7
  } phase_e;

  // packed from the top bit down: cause, size, data, kind (kind lowest)
  typedef struct packed {
    logic [2:0]  cause;
    logic [30:0] size;
    logic [7:0]  data;
    logic [2:0]  kind;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic res_t mk_res(input kind_e k, input logic [7:0] b, input logic [30:0] s,
                                  input cause_e c);
    res_t r;
    r.kind  = k;
    r.data  = b;
    r.size  = s;
    r.cause = c;
    return r;
  endfunction

endpackage

// ===== hdl/ymodem_receiver.sv =====
// ----------------------------------------------------------------------------
// ymodem_receiver
// YMODEM CRC-16 single file receiver with stream in/out and APB register.
// ----------------------------------------------------------------------------
// Input words (s_axis): tdata = {rx_data, req_type}; start, received byte or
// tick. Each word produces zero to four result words on m_axis; tlast marks
// the final result of a word. One word is processed in the cycle it is
// accepted and its results land in a four-entry result buffer, so the first
// result is offered the next cycle; the buffer then drains one per cycle
// while m_axis_tready is high. The next word is taken as soon as the
// buffer is empty or will be empty after this cycle.
// When m_axis_tready is low a non-empty buffer holds and s_axis_tready is low.
// Reset clears the protocol state to idle, the buffer to empty and
// timeout_ticks (APB address 0) to 3000. Inside a packet the timeout is
// twice timeout_ticks.
// ----------------------------------------------------------------------------
module ymodem_receiver import ymr_pkg::*; #(
  parameter int unsigned LongBlock  = LongBlockDef,
  parameter int unsigned ShortBlock = ShortBlockDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] req_type, [9:2] rx_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [2:0] out_kind, [10:3] out_byte,
                                      // [41:11] file_size, [44:42] err_cause
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = $clog2(LongBlock + 4);

  logic [31:0] timeout_q;
  phase_e      phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic        long_q, long_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crch_q, crch_d;
  logic        name_done_q, name_done_d;
  logic [30:0] size_q, size_d;
  logic        parsing_q, parsing_d, fin_q, fin_d, neg_q, neg_d;
  logic [30:0] rem_q, rem_d;
  logic        nolim_q, nolim_d;
  logic [32:0] tick_q, tick_d;
  logic        sbad_q, sbad_d, cbad_q, cbad_d;

  res_t        buf_q [4];
  res_t        res   [4];
  logic [2:0]  cnt_q, n;
  logic [1:0]  rd_q;

  logic        in_acc, out_acc;
  logic [1:0]  req;
  logic [7:0]  b;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? timeout_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      timeout_q <= pwdata;
    end
  end

  assign req = s_axis_tdata[1:0];
  assign b   = s_axis_tdata[9:2];

  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {3'b000, buf_q[rd_q]};
  assign m_axis_tlast  = (cnt_q == 3'd1);

  always_comb begin
    logic [IdxW-1:0] len;
    logic [7:0]  expv;
    logic [32:0] limit;
    logic [35:0] prod;
    logic [IdxW-1:0] d;
    logic        fail;
    cause_e      fc;
    logic        fin_pkt;
    logic [30:0] sz;

    phase_d = phase_q; idx_d = idx_q; long_d = long_q; seq_d = seq_q;
    crc_d = crc_q; crch_d = crch_q; name_done_d = name_done_q; size_d = size_q;
    parsing_d = parsing_q; fin_d = fin_q; neg_d = neg_q; rem_d = rem_q;
    nolim_d = nolim_q; tick_d = tick_q; sbad_d = sbad_q; cbad_d = cbad_q;
    n = 3'd0;
    fail = 1'b0; fc = E_NONE; fin_pkt = 1'b0;
    for (int i = 0; i < 4; i++) res[i] = '0;
    len  = long_q ? IdxW'(LongBlock) : IdxW'(ShortBlock);
    expv = (phase_q == PH_FINAL_PKT) ? 8'h00 : seq_q;
    d    = idx_q - IdxW'(2);
    prod = 36'(size_q) * 36'd10 + 36'(b - 8'h30);
    sz   = neg_q ? 31'd0 : size_q;
    limit = (phase_q == PH_HDR_PKT || phase_q == PH_DATA_PKT || phase_q == PH_FINAL_PKT)
            ? {timeout_q, 1'b0} : {1'b0, timeout_q};

    if (in_acc) begin
      case (req)
        REQ_START: begin
          seq_d = '0; name_done_d = 1'b0; size_d = '0; parsing_d = 1'b0;
          fin_d = 1'b0; neg_d = 1'b0; rem_d = '0; nolim_d = 1'b0;
          phase_d = PH_WAIT_START; long_d = 1'b0; idx_d = '0; crc_d = '0;
          crch_d = '0; sbad_d = 1'b0; cbad_d = 1'b0; tick_d = '0;
          res[0] = mk_res(K_SEND, ChC, '0, E_NONE); n = 3'd1;
        end
        REQ_BYTE: begin
          unique case (phase_q)
            PH_WAIT_START, PH_DATA_WAIT: begin
              tick_d = '0;
              if (phase_q == PH_DATA_WAIT && b == ChEot) begin
                res[0] = mk_res(K_SEND, ChNak, '0, E_NONE); n = 3'd1;
                phase_d = PH_END_EOT;
              end else if (b == ChSoh || b == ChStx) begin
                phase_d = (phase_q == PH_WAIT_START) ? PH_HDR_PKT : PH_DATA_PKT;
                long_d = (b == ChStx); idx_d = '0; crc_d = '0; crch_d = '0;
                sbad_d = 1'b0; cbad_d = 1'b0;
              end else begin
                fail = 1'b1; fc = E_START;
              end
            end
            PH_END_EOT: begin
              tick_d = '0;
              if (b == ChEot) begin
                res[0] = mk_res(K_SEND, ChAck, '0, E_NONE);
                res[1] = mk_res(K_SEND, ChC, '0, E_NONE); n = 3'd2;
                phase_d = PH_FINAL_WAIT;
              end else begin
                fail = 1'b1; fc = E_END;
              end
            end
            PH_FINAL_WAIT: begin
              tick_d = '0;
              if (b == ChSoh) begin
                phase_d = PH_FINAL_PKT; long_d = 1'b0; idx_d = '0; crc_d = '0;
                crch_d = '0; sbad_d = 1'b0; cbad_d = 1'b0;
              end else begin
                fail = 1'b1; fc = E_END;
              end
            end
            PH_HDR_PKT, PH_DATA_PKT, PH_FINAL_PKT: begin
              tick_d = '0;
              idx_d = idx_q + IdxW'(1);
              if (idx_q == '0) begin
                sbad_d = (b != expv);
              end else if (idx_q == IdxW'(1)) begin
                cbad_d = (b != (8'hFF - expv));
              end else if (idx_q < len + IdxW'(2)) begin
                crc_d = crc_step(crc_q, b);
                if (phase_q == PH_HDR_PKT) begin
                  if (!name_done_q) begin
                    if (b == 8'h00) name_done_d = 1'b1;
                    else begin
                      res[0] = mk_res(K_NAME, b, '0, E_NONE); n = 3'd1;
                    end
                  end else if (!fin_q) begin
                    if (!parsing_q && (b == 8'h20 || (b >= 8'd9 && b <= 8'd13))) begin
                      parsing_d = 1'b0;
                    end else if (!parsing_q && b == 8'h2D) begin
                      parsing_d = 1'b1; neg_d = 1'b1;
                    end else if (!parsing_q && b == 8'h2B) begin
                      parsing_d = 1'b1;
                    end else begin
                      parsing_d = 1'b1;
                      if (b >= 8'h30 && b <= 8'h39) begin
                        size_d = (prod > 36'(SizeMax)) ? SizeMax : prod[30:0];
                      end else begin
                        fin_d = 1'b1;
                      end
                    end
                  end
                end else if (phase_q == PH_DATA_PKT &&
                             (nolim_q || 31'(d) < rem_q)) begin
                  res[0] = mk_res(K_PAYLOAD, b, '0, E_NONE); n = 3'd1;
                end
              end else if (idx_q == len + IdxW'(2)) begin
                crch_d = b;
              end else begin
                fin_pkt = 1'b1;
                idx_d = idx_q;
                if (sbad_q) begin
                  fail = 1'b1; fc = E_SEQ;
                end else if (cbad_q) begin
                  fail = 1'b1; fc = E_COMP;
                end else if (phase_q != PH_FINAL_PKT && crc_q != {crch_q, b}) begin
                  fail = 1'b1; fc = E_CRC;
                end else if (phase_q == PH_HDR_PKT) begin
                  nolim_d = (sz == '0); rem_d = sz;
                  res[0] = mk_res(K_HDR_OK, '0, sz, E_NONE);
                  res[1] = mk_res(K_SEND, ChAck, '0, E_NONE);
                  res[2] = mk_res(K_SEND, ChC, '0, E_NONE); n = 3'd3;
                  seq_d = 8'd1; phase_d = PH_DATA_WAIT;
                end else if (phase_q == PH_DATA_PKT) begin
                  if (!nolim_q) rem_d = (rem_q < 31'(len)) ? '0 : rem_q - 31'(len);
                  res[0] = mk_res(K_BLK_OK, '0, '0, E_NONE);
                  res[1] = mk_res(K_SEND, ChAck, '0, E_NONE); n = 3'd2;
                  seq_d = seq_q + 8'd1; phase_d = PH_DATA_WAIT;
                end else begin
                  res[0] = mk_res(K_SEND, ChAck, '0, E_NONE);
                  res[1] = mk_res(K_SUCCESS, '0, '0, E_NONE); n = 3'd2;
                  phase_d = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            tick_d = tick_q + 33'd1;
            if (tick_d >= limit) begin
              tick_d = '0;
              if (phase_q == PH_WAIT_START) begin
                res[0] = mk_res(K_SEND, ChC, '0, E_NONE); n = 3'd1;
              end else begin
                fail = 1'b1; fc = E_TIMEOUT;
              end
            end
          end
        end
        default: ;
      endcase
      if (fail) begin
        res[0] = mk_res(K_SEND, ChCan, '0, E_NONE);
        res[1] = mk_res(K_SEND, ChCan, '0, E_NONE);
        res[2] = mk_res(K_SEND, ChCan, '0, E_NONE);
        res[3] = mk_res(K_ERROR, '0, '0, fc); n = 3'd4;
        phase_d = PH_IDLE;
      end else if (fin_pkt) begin
        tick_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; idx_q <= '0; long_q <= 1'b0; seq_q <= '0; crc_q <= '0;
      crch_q <= '0; name_done_q <= 1'b0; size_q <= '0; parsing_q <= 1'b0;
      fin_q <= 1'b0; neg_q <= 1'b0; rem_q <= '0; nolim_q <= 1'b0; tick_q <= '0;
      sbad_q <= 1'b0; cbad_q <= 1'b0; cnt_q <= '0; rd_q <= '0;
    end else begin
      phase_q <= phase_d; idx_q <= idx_d; long_q <= long_d; seq_q <= seq_d;
      crc_q <= crc_d; crch_q <= crch_d; name_done_q <= name_done_d;
      size_q <= size_d; parsing_q <= parsing_d; fin_q <= fin_d; neg_q <= neg_d;
      rem_q <= rem_d; nolim_q <= nolim_d; tick_q <= tick_d; sbad_q <= sbad_d;
      cbad_q <= cbad_d;
      if (in_acc && n != 3'd0) begin
        cnt_q <= n; rd_q <= '0;
      end else if (out_acc) begin
        cnt_q <= cnt_q - 3'd1; rd_q <= rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n != 3'd0) begin
      for (int i = 0; i < 4; i++) buf_q[i] <= res[i];
    end
  end

endmodule

// ===== tb/sv/ymodem_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymodem_checker
// Watches the input, output and register ports of the YMODEM receiver,
// predicts the result words of every accepted input word and compares them
// field by field, in order, with what the block sends.
// ----------------------------------------------------------------------------
module ymodem_checker import ymr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [30:0] size;
    cause_e      cause;
    logic        last;
  } rx_result_t;

  rx_result_t  rx_results_q[$];
  int          word_results;

  logic [31:0] tmo_ticks;
  phase_e      phase;
  logic [10:0] byte_idx;
  logic        long_pkt;
  logic [7:0]  exp_seq;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  logic        name_done;
  logic [30:0] size_acc;
  logic        size_active;
  logic        size_done;
  logic        size_neg;
  logic [30:0] bytes_left;
  logic        unlimited;
  logic [32:0] tick_cnt;
  logic        seq_bad;
  logic        comp_bad;

  initial fail_count = 0;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic push_result(input kind_e k, input logic [7:0] b, input logic [30:0] s,
                             input cause_e c);
    rx_result_t r;
    if (word_results < 4) begin
      r.kind  = k;
      r.data  = b;
      r.size  = s;
      r.cause = c;
      r.last  = 1'b0;
      rx_results_q.push_back(r);
      word_results++;
    end
  endtask

  task automatic abort_transfer(input cause_e c);
    repeat (3) push_result(K_SEND, ChCan, '0, E_NONE);
    push_result(K_ERROR, 8'h00, '0, c);
    phase = PH_IDLE;
  endtask

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  task automatic open_packet(input phase_e ph, input logic lng);
    phase    = ph;
    long_pkt = lng;
    byte_idx = '0;
    crc_acc  = '0;
    crc_rx   = '0;
    seq_bad  = 1'b0;
    comp_bad = 1'b0;
  endtask

  task automatic parse_header_byte(input logic [7:0] b);
    logic [63:0] v;
    if (!name_done) begin
      if (b == 8'h00) name_done = 1'b1;
      else push_result(K_NAME, b, '0, E_NONE);
      return;
    end
    if (size_done) return;
    if (!size_active) begin
      if (b == 8'h20 || (b >= 8'd9 && b <= 8'd13)) return;
      size_active = 1'b1;
      if (b == 8'h2D) begin
        size_neg = 1'b1;
        return;
      end
      if (b == 8'h2B) return;
    end
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 64'(size_acc) * 10 + 64'(b - 8'h30);
      size_acc = (v > 64'(SizeMax)) ? SizeMax : v[30:0];
    end else begin
      size_done = 1'b1;
    end
  endtask

  task automatic close_packet();
    logic [30:0] blen;
    logic [30:0] sz;
    blen = long_pkt ? 31'(LongBlockDef) : 31'(ShortBlockDef);
    if (seq_bad) begin
      abort_transfer(E_SEQ);
      return;
    end
    if (comp_bad) begin
      abort_transfer(E_COMP);
      return;
    end
    if (phase != PH_FINAL_PKT && crc_acc != crc_rx) begin
      abort_transfer(E_CRC);
      return;
    end
    tick_cnt = '0;
    if (phase == PH_HDR_PKT) begin
      sz = size_neg ? '0 : size_acc;
      unlimited  = (sz == '0);
      bytes_left = sz;
      push_result(K_HDR_OK, 8'h00, sz, E_NONE);
      push_result(K_SEND, ChAck, '0, E_NONE);
      push_result(K_SEND, ChC, '0, E_NONE);
      exp_seq = 8'd1;
      phase   = PH_DATA_WAIT;
    end else if (phase == PH_DATA_PKT) begin
      if (!unlimited) bytes_left -= (bytes_left < blen) ? bytes_left : blen;
      push_result(K_BLK_OK, 8'h00, '0, E_NONE);
      push_result(K_SEND, ChAck, '0, E_NONE);
      exp_seq = exp_seq + 8'd1;
      phase   = PH_DATA_WAIT;
    end else begin
      push_result(K_SEND, ChAck, '0, E_NONE);
      push_result(K_SUCCESS, 8'h00, '0, E_NONE);
      phase = PH_IDLE;
    end
  endtask

  task automatic packet_byte(input logic [7:0] b);
    logic [10:0] blen;
    logic [7:0]  want;
    blen = long_pkt ? 11'(LongBlockDef) : 11'(ShortBlockDef);
    want = (phase == PH_FINAL_PKT) ? 8'h00 : exp_seq;
    tick_cnt = '0;
    if (byte_idx == 0) begin
      seq_bad = (b != want);
    end else if (byte_idx == 1) begin
      comp_bad = (b != 8'hFF - want);
    end else if (byte_idx < blen + 2) begin
      crc_acc = crc16_next(crc_acc, b);
      if (phase == PH_HDR_PKT) parse_header_byte(b);
      else if (phase == PH_DATA_PKT && (unlimited || 31'(byte_idx - 2) < bytes_left))
        push_result(K_PAYLOAD, b, '0, E_NONE);
    end else if (byte_idx == blen + 2) begin
      crc_rx = {8'h00, b};
    end else begin
      crc_rx = {crc_rx[7:0], b};
      close_packet();
      return;
    end
    byte_idx = byte_idx + 1;
  endtask

  task automatic predict_word(input logic [1:0] req, input logic [7:0] b);
    logic [32:0] lim;
    word_results = 0;
    case (req)
      REQ_START: begin
        exp_seq     = '0;
        name_done   = 1'b0;
        size_acc    = '0;
        size_active = 1'b0;
        size_done   = 1'b0;
        size_neg    = 1'b0;
        bytes_left  = '0;
        unlimited   = 1'b0;
        open_packet(PH_WAIT_START, 1'b0);
        tick_cnt = '0;
        push_result(K_SEND, ChC, '0, E_NONE);
      end
      REQ_BYTE: begin
        case (phase)
          PH_WAIT_START, PH_DATA_WAIT: begin
            tick_cnt = '0;
            if (phase == PH_DATA_WAIT && b == ChEot) begin
              push_result(K_SEND, ChNak, '0, E_NONE);
              phase = PH_END_EOT;
            end else if (b == ChSoh || b == ChStx) begin
              open_packet(phase == PH_WAIT_START ? PH_HDR_PKT : PH_DATA_PKT, b == ChStx);
            end else begin
              abort_transfer(E_START);
            end
          end
          PH_END_EOT: begin
            tick_cnt = '0;
            if (b == ChEot) begin
              push_result(K_SEND, ChAck, '0, E_NONE);
              push_result(K_SEND, ChC, '0, E_NONE);
              phase = PH_FINAL_WAIT;
            end else begin
              abort_transfer(E_END);
            end
          end
          PH_FINAL_WAIT: begin
            tick_cnt = '0;
            if (b == ChSoh) open_packet(PH_FINAL_PKT, 1'b0);
            else abort_transfer(E_END);
          end
          PH_HDR_PKT, PH_DATA_PKT, PH_FINAL_PKT: packet_byte(b);
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (phase != PH_IDLE) begin
          lim = {1'b0, tmo_ticks};
          if (phase == PH_HDR_PKT || phase == PH_DATA_PKT || phase == PH_FINAL_PKT)
            lim = lim << 1;
          tick_cnt = tick_cnt + 1;
          if (tick_cnt >= lim) begin
            tick_cnt = '0;
            if (phase == PH_WAIT_START) push_result(K_SEND, ChC, '0, E_NONE);
            else abort_transfer(E_TIMEOUT);
          end
        end
      end
      default: ;
    endcase
    if (word_results > 0) rx_results_q[rx_results_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rx_result_t e;
    if (!rst_ni) begin
      rx_results_q.delete();
      tmo_ticks   = TimeoutRst;
      phase       = PH_IDLE;
      byte_idx    = '0;
      long_pkt    = 1'b0;
      exp_seq     = '0;
      crc_acc     = '0;
      crc_rx      = '0;
      name_done   = 1'b0;
      size_acc    = '0;
      size_active = 1'b0;
      size_done   = 1'b0;
      size_neg    = 1'b0;
      bytes_left  = '0;
      unlimited   = 1'b0;
      tick_cnt    = '0;
      seq_bad     = 1'b0;
      comp_bad    = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'd0) tmo_ticks = pwdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (rx_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
        end else begin
          e = rx_results_q.pop_front();
          if (m_axis_tdata[2:0] != e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", m_axis_tdata[2:0], e.kind));
          if (m_axis_tdata[10:3] != e.data)
            report_mismatch($sformatf("byte %h, want %h", m_axis_tdata[10:3], e.data));
          if (m_axis_tdata[41:11] != e.size)
            report_mismatch($sformatf("size %0d, want %0d", m_axis_tdata[41:11], e.size));
          if (m_axis_tdata[44:42] != e.cause)
            report_mismatch($sformatf("cause %0d, want %0d", m_axis_tdata[44:42], e.cause));
          if (m_axis_tlast != e.last)
            report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast, e.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata[1:0], s_axis_tdata[9:2]);
    end
    pending = rx_results_q.size();
  end

endmodule

// ===== tb/sv/tb_ymodem_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ymodem_receiver
// Drives the YMODEM receiver with directed corner cases and randomized
// transfers (headers, data blocks, end exchange, injected faults) under
// several timeout settings and idle/stall patterns; the checker judges.
// ----------------------------------------------------------------------------
module tb_ymodem_receiver;
  import ymr_pkg::*;

  localparam int IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          phase_words;
  int          word_budget = 1 << 20;
  logic        sender_gaps = 1'b0;
  logic        recv_stalls = 1'b0;
  int unsigned tmo_now = 3000;
  logic [7:0]  body [1024];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ymodem_receiver u_top (.*);

  ymodem_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= recv_stalls ? ($urandom_range(99) >= 57) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] crc16(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  // words beyond the phase budget are dropped, cutting the transfer short
  task automatic send_word(input logic [1:0] req, input logic [7:0] b);
    if (phase_words >= word_budget) return;
    while (sender_gaps && $urandom_range(99) < 57) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b, req};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    phase_words++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 3) send_word(REQ_TICK, 8'($urandom));
    send_word(REQ_BYTE, b);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= v;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tmo_now = v;
    @(posedge clk_i);
  endtask

  // fault: 0 clean, 1 bad seq, 2 bad complement, 3 bad crc, 4 tick burst
  task automatic send_packet(input logic [7:0] head, input logic [7:0] seq, input int len,
                             input int fault);
    logic [15:0] crc;
    int          cut;
    crc = '0;
    cut = $urandom_range(len - 1);
    send_byte(head);
    send_byte(fault == 1 ? seq ^ 8'($urandom_range(1, 255)) : seq);
    send_byte(fault == 2 ? ~seq ^ 8'($urandom_range(1, 255)) : ~seq);
    for (int i = 0; i < len; i++) begin
      if (fault == 4 && i == cut && tmo_now <= 10)
        repeat (2 * tmo_now) send_word(REQ_TICK, 8'($urandom));
      crc = crc16(crc, body[i]);
      send_byte(body[i]);
    end
    send_byte(crc[15:8] ^ (fault == 3 ? 8'($urandom_range(1, 255)) : 8'h00));
    send_byte(crc[7:0]);
  endtask

  function automatic int pick_fault();
    return ($urandom_range(99) < 90) ? 0 : int'($urandom_range(1, 4));
  endfunction

  function automatic int pick_len(output logic [7:0] head);
    if ($urandom_range(15) == 0) begin
      head = ChStx;
      return LongBlockDef;
    end
    head = ChSoh;
    return ShortBlockDef;
  endfunction

  task automatic run_transfer();
    int         nlen;
    int         pos;
    int         len;
    string      digits;
    logic [7:0] head;
    send_word(REQ_START, 8'($urandom));
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(0, tmo_now <= 10 ? 2 * tmo_now : 3)) send_word(REQ_TICK, 8'($urandom));
    for (int i = 0; i < 1024; i++) body[i] = 8'h00;
    nlen = ($urandom_range(19) == 0) ? 128 : $urandom_range(1, 8);
    for (int i = 0; i < nlen; i++) body[i] = 8'($urandom_range(1, 255));
    pos = nlen + 1;
    if (nlen < 128) begin
      repeat ($urandom_range(0, 2)) begin
        body[pos] = $urandom_range(1) ? 8'h20 : 8'($urandom_range(9, 13));
        pos++;
      end
      case ($urandom_range(3))
        1: begin body[pos] = 8'h2B; pos++; end
        2: begin body[pos] = 8'h2D; pos++; end
        default: ;
      endcase
      case ($urandom_range(4))
        0: digits = "99999999999999";
        1: digits = "0";
        2: digits = "";
        default: digits = $sformatf("%0d", $urandom_range(0, 400));
      endcase
      for (int i = 0; i < digits.len(); i++) begin
        body[pos] = digits[i];
        pos++;
      end
      if ($urandom_range(3) == 0) body[pos] = 8'($urandom);
    end
    len = pick_len(head);
    send_packet(head, 8'h00, len, pick_fault());
    for (int k = 0; k < int'($urandom_range(0, 3)); k++) begin
      len = pick_len(head);
      for (int i = 0; i < len; i++) body[i] = 8'($urandom);
      send_packet(head, 8'(k + 1), len, pick_fault());
    end
    send_byte($urandom_range(19) == 0 ? 8'($urandom) : ChEot);
    send_byte($urandom_range(19) == 0 ? 8'($urandom) : ChEot);
    for (int i = 0; i < 128; i++) body[i] = 8'h00;
    send_packet($urandom_range(19) == 0 ? ChStx : ChSoh, 8'h00, ShortBlockDef, pick_fault());
  endtask

  initial begin
    logic [31:0] tmo_set [4];
    int          phase_len [4];
    tmo_set = '{32'd4, 32'hFFFF_FFFF, 32'd5, 32'd2};
    phase_len = '{280, 55, 55, 55};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle words, unknown request, bad start bytes, restarts
    send_word(REQ_BYTE, 8'hAA);
    send_word(REQ_TICK, 8'h55);
    send_word(2'd3, 8'hFF);
    send_word(REQ_START, 8'h00);
    send_word(REQ_BYTE, 8'h55);
    send_word(REQ_START, 8'h00);
    send_word(REQ_BYTE, ChEot);
    send_word(REQ_START, 8'h00);
    send_word(REQ_START, 8'h00);
    send_word(REQ_BYTE, ChSoh);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_START, 8'h00);
    send_word(REQ_BYTE, 8'h00);
    settle();
    // shortest timeout: resend C, then timeout inside a packet
    apb_write(32'd1);
    send_word(REQ_START, 8'h00);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_BYTE, ChSoh);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_TICK, 8'h00);
    settle();
    apb_write(32'hFFFF_FFFF);
    send_word(REQ_START, 8'h00);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_BYTE, 8'hFF);
    settle();

    for (int p = 0; p < 4; p++) begin
      apb_write(tmo_set[p]);
      sender_gaps = (p == 1 || p == 3);
      recv_stalls = (p == 2 || p == 3);
      phase_words = 0;
      word_budget = phase_len[p];
      while (phase_words < word_budget) run_transfer();
      settle();
    end

    sender_gaps = 1'b0;
    recv_stalls = 1'b0;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
